[rtl/core/mat_pkg.sv]
// mat_pkg: shared types and constants for the multichannel average threshold block
// threshold register layout, reset values and the window control struct
// no dependencies
package mat_pkg;

  localparam int NUM_OUT   = 5;
  localparam int REG_COUNT = 5;
  localparam int THR_W     = 10;
  localparam int REG_IDX_W = 3;

  localparam int WINDOW_DEPTH_DEF  = 8;
  localparam int CHANNEL_COUNT_DEF = 5;
  localparam int SAMPLE_BITS_DEF   = 10;

  typedef logic [THR_W-1:0]     thr_t;
  typedef thr_t [NUM_OUT-1:0]   thr_arr_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_THR_CH0 = 3'd0;

  localparam thr_arr_t THR_RESET = {10'd775, 10'd806, 10'd620, 10'd698, 10'd853};

  typedef struct packed {
    logic load;
    logic commit;
  } win_ctrl_t;

endpackage

[rtl/core/mat_cfg_regs.sv]
// mat_cfg_regs: per-channel threshold registers behind the plain write port
// depends on mat_pkg
module mat_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  mat_pkg::reg_idx_t  cfg_idx_i,
  input  mat_pkg::thr_t      cfg_wdata_i,
  output mat_pkg::thr_arr_t  thr_o
);
  import mat_pkg::*;

  thr_arr_t thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        if (cfg_idx_i == REG_THR_CH0 + REG_IDX_W'(i)) begin
          thr_q[i] <= cfg_wdata_i;
        end
      end
    end
  end

  assign thr_o = thr_q;

endmodule

[rtl/core/mat_window.sv]
// mat_window: per-channel sample rings, running sums and channel/slot counters
// ring read at item accept, write and sum update in the cycle after; depends on mat_pkg
module mat_window #(
  parameter int WINDOW_DEPTH  = mat_pkg::WINDOW_DEPTH_DEF,
  parameter int CHANNEL_COUNT = mat_pkg::CHANNEL_COUNT_DEF,
  parameter int SAMPLE_BITS   = mat_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mat_pkg::win_ctrl_t     ctrl_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [CHANNEL_COUNT-1:0][SAMPLE_BITS+$clog2(WINDOW_DEPTH)-1:0] sums_o
);
  import mat_pkg::*;

  localparam int Depth = CHANNEL_COUNT * WINDOW_DEPTH;
  localparam int AddrW = $clog2(Depth);
  localparam int ChW   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int SlotW = $clog2(WINDOW_DEPTH);
  localparam int SumW  = SAMPLE_BITS + SlotW;

  logic [ChW-1:0]   ch_q, ch_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr_q;
  logic [ChW-1:0]   wr_ch_q;
  logic [SAMPLE_BITS-1:0] mem [Depth];
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic             rd_vld_q;
  logic [Depth-1:0] vld_q;
  logic [SAMPLE_BITS-1:0] old_val;
  logic [SumW-1:0]  sums_q [CHANNEL_COUNT];

  assign rd_addr = AddrW'(int'(ch_q) * WINDOW_DEPTH + int'(slot_q));

  always_comb begin
    ch_d   = ch_q;
    slot_d = slot_q;
    if (ch_q == ChW'(CHANNEL_COUNT - 1)) begin
      ch_d   = '0;
      slot_d = (slot_q == SlotW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + SlotW'(1);
    end else begin
      ch_d = ch_q + ChW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q     <= '0;
      slot_q   <= '0;
      rd_vld_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      if (ctrl_i.load) begin
        ch_q     <= ch_d;
        slot_q   <= slot_d;
        rd_vld_q <= vld_q[rd_addr];
      end
      if (ctrl_i.commit) begin
        vld_q[wr_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rd_data_q <= mem[rd_addr];
      wr_addr_q <= rd_addr;
      wr_ch_q   <= ch_q;
    end
    if (ctrl_i.commit) begin
      mem[wr_addr_q] <= sample_i;
    end
  end

  assign old_val = rd_vld_q ? rd_data_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        sums_q[c] <= '0;
      end
    end else if (ctrl_i.commit) begin
      sums_q[wr_ch_q] <= sums_q[wr_ch_q] - SumW'(old_val) + SumW'(sample_i);
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      sums_o[c] = sums_q[c];
    end
  end

endmodule

[rtl/core/mat_compare.sv]
// mat_compare: average-above-threshold test for each reported channel
// avg > thr is tested as sum >= (thr + 1) * depth; depends on mat_pkg
module mat_compare #(
  parameter int WINDOW_DEPTH  = mat_pkg::WINDOW_DEPTH_DEF,
  parameter int CHANNEL_COUNT = mat_pkg::CHANNEL_COUNT_DEF,
  parameter int SAMPLE_BITS   = mat_pkg::SAMPLE_BITS_DEF
) (
  input  logic [CHANNEL_COUNT-1:0][SAMPLE_BITS+$clog2(WINDOW_DEPTH)-1:0] sums_i,
  input  mat_pkg::thr_arr_t            thr_i,
  output logic [mat_pkg::NUM_OUT-1:0]  bits_o
);
  import mat_pkg::*;

  localparam int SumW = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int LimW = THR_W + 1 + $clog2(WINDOW_DEPTH);
  localparam int CmpW = (SumW > LimW) ? SumW : LimW;

  for (genvar c = 0; c < NUM_OUT; c++) begin : g_ch
    if (c < CHANNEL_COUNT) begin : g_live
      logic [CmpW-1:0] lim;
      assign lim = (CmpW'(thr_i[c]) + CmpW'(1)) * CmpW'(WINDOW_DEPTH);
      assign bits_o[c] = (CmpW'(sums_i[c]) >= lim);
    end else begin : g_absent
      assign bits_o[c] = 1'b0;
    end
  end

endmodule

[rtl/core/multichannel_average_threshold_top.sv]
// multichannel_average_threshold_top: moving average threshold detector, top level
// input register, result register, handshakes; uses mat_pkg, mat_cfg_regs,
// mat_window and mat_compare
//
// Samples arrive in round-robin channel order; each lands in its channel's ring and
// updates that channel's running sum. A tick item reports one bit per channel, set
// when the truncated window average is strictly above the channel threshold. One
// item is accepted per cycle unless a tick waits in the input register on an unread
// result. A sample finishes (ring write, sum update) in the cycle after accept; a
// tick result is registered as it leaves the input register and is held in the
// result register while new samples enter. The ring's single read port is used at
// accept; per-entry valid bits clear the ring at reset, with no clearing pass.
module multichannel_average_threshold_top #(
  parameter int WINDOW_DEPTH  = mat_pkg::WINDOW_DEPTH_DEF,
  parameter int CHANNEL_COUNT = mat_pkg::CHANNEL_COUNT_DEF,
  parameter int SAMPLE_BITS   = mat_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  mat_pkg::reg_idx_t      cfg_idx_i,
  input  mat_pkg::thr_t          cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   mode_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   bit_ch0_o,
  output logic                   bit_ch1_o,
  output logic                   bit_ch2_o,
  output logic                   bit_ch3_o,
  output logic                   bit_ch4_o
);
  import mat_pkg::*;

  localparam int SumW = SAMPLE_BITS + $clog2(WINDOW_DEPTH);

  logic                   inq_valid_q;
  logic                   inq_mode_q;
  logic [SAMPLE_BITS-1:0] inq_sample_q;
  logic                   out_valid_q;
  logic [NUM_OUT-1:0]     res_q;
  logic                   accept;
  logic                   advance;
  win_ctrl_t              win_ctrl;
  thr_arr_t               thr;
  logic [CHANNEL_COUNT-1:0][SumW-1:0] sums;
  logic [NUM_OUT-1:0]     cmp_bits;

  assign advance    = inq_valid_q && (!inq_mode_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !inq_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  assign win_ctrl.load   = accept && !mode_i;
  assign win_ctrl.commit = advance && !inq_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        inq_valid_q <= 1'b1;
      end else if (advance) begin
        inq_valid_q <= 1'b0;
      end
      if (advance && inq_mode_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      inq_mode_q   <= mode_i;
      inq_sample_q <= sample_i;
    end
    if (advance && inq_mode_q) begin
      res_q <= cmp_bits;
    end
  end

  mat_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .thr_o       (thr)
  );

  mat_window #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (win_ctrl),
    .sample_i (inq_sample_q),
    .sums_o   (sums)
  );

  mat_compare #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_compare (
    .sums_i (sums),
    .thr_i  (thr),
    .bits_o (cmp_bits)
  );

  assign out_valid_o = out_valid_q;
  assign bit_ch0_o   = res_q[0];
  assign bit_ch1_o   = res_q[1];
  assign bit_ch2_o   = res_q[2];
  assign bit_ch3_o   = res_q[3];
  assign bit_ch4_o   = res_q[4];

endmodule
